// ----- rtl/fsa_pkg.sv -----
// shared types, codes and constants of the fixed slot pool allocator
package fsa_pkg;

    localparam int MAX_SLOTS_DEF = 256;
    localparam int WORD_BITS     = 32;

    localparam logic [31:0] BASE_RESET  = 32'd4096;
    localparam logic [15:0] OSIZE_RESET = 16'd1;
    localparam logic [8:0]  SLOTS_RESET = 9'd0;

    // register indexes on the configuration port
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_OSIZE = 2'd1;
    localparam logic [1:0] REG_SLOTS = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SIZE    = 3'd1,
        ST_FULL    = 3'd2,
        ST_NULL    = 3'd3,
        ST_OUTSIDE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_ADDR,
        S_DIV,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [15:0] request_size;
        logic [31:0] free_address;
    } t_request;

    typedef struct packed {
        logic [31:0] slot_address;
        logic [2:0]  status;
        logic [8:0]  used_slots;
    } t_result;

endpackage

// ----- rtl/fsa_div.sv -----
// serial restoring divider, one quotient bit per cycle
module fsa_div
    import fsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_div;
    logic [31:0] r_quo;

    logic [16:0] trial;
    logic        fits;
    logic [16:0] diff;

    always_comb begin
        trial = {r_rem, r_quo[31]};
        fits  = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[15:0] : trial[15:0];
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished run");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_div != 16'd0) |-> r_rem < r_div)
        else $error("partial remainder not below divisor");
`endif

endmodule

// ----- rtl/fixed_slot_pool_allocator.sv -----
// fixed slot pool allocator: used-slot bitmap in a word memory, first fit
// allocate: a wrong size or full pool is refused at once, else each bitmap word scanned
// (32 slots a word) is read and checked, then the address is formed; free: null, below
// base or zero size refused at once; else serial divide, bound check, read, write back
// one request at a time; the next is taken once the result sits in the output register
// reset: registers to base 4096, size 1, count 0; bitmap rows flagged empty at once
module fixed_slot_pool_allocator
    import fsa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_request    i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output t_result     o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROWS  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W = ROW_W + 5;
    localparam int PRD_W = IDX_W + 16;

    // configuration registers
    logic [31:0] r_base;
    logic [15:0] r_osize;
    logic [8:0]  r_slots;

    // control and datapath registers
    t_state      r_state, n_state;
    logic [8:0]  r_used, n_used;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PRD_W-1:0] r_prod, n_prod;
    logic [31:0] r_addr, n_addr;
    t_status     r_status, n_status;
    logic        r_rsp_valid, n_rsp_valid;
    t_result     r_rsp, n_rsp;

    // bitmap memory and per-row valid flags
    logic [WORD_BITS-1:0] r_mem [ROWS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [ROWS-1:0]      r_row_vld;
    logic                 r_rd_vld;
    logic [ROW_W-1:0]     mem_raddr;
    logic [ROW_W-1:0]     mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_we;
    logic [WORD_BITS-1:0] row_word;

    logic        cfg_wr;
    logic        cfg_take;
    logic [8:0]  live_n;
    logic        req_acc;
    logic        div_start;
    logic        div_done;
    logic [31:0] quotient;
    logic [31:0] dividend;
    logic        zero_found;
    logic [4:0]  zero_bit;
    logic [IDX_W-1:0] alloc_idx;
    logic [31:0] next_start;
    logic [ROW_W-1:0] free_row;
    logic [4:0]  free_bit;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_take = cfg_wr && (r_used == 9'd0) && (paddr[3:2] <= REG_SLOTS);
    assign live_n   = (32'(r_slots) > MAX_SLOTS) ? 9'(MAX_SLOTS) : r_slots;
    assign req_acc  = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign dividend    = i_req.free_address - r_base;
    assign free_row    = quotient[ROW_W+4:5];
    assign free_bit    = quotient[4:0];
    assign row_word    = r_rd_vld ? r_rdata : '0;

    always_comb begin
        unique case (paddr[3:2])
            REG_BASE:  prdata = r_base;
            REG_OSIZE: prdata = {16'd0, r_osize};
            REG_SLOTS: prdata = {23'd0, r_slots};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_osize <= OSIZE_RESET;
            r_slots <= SLOTS_RESET;
        end else if (cfg_take) begin
            unique case (paddr[3:2])
                REG_BASE:  r_base  <= pwdata;
                REG_OSIZE: r_osize <= pwdata[15:0];
                REG_SLOTS: r_slots <= pwdata[8:0];
                default:   ;
            endcase
        end
    end

    fsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_osize),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // lowest free slot in the fetched word
    always_comb begin
        zero_found = 1'b0;
        zero_bit   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!row_word[b]) begin
                zero_found = 1'b1;
                zero_bit   = 5'(b);
            end
        end
    end

    assign alloc_idx  = {r_row, zero_bit};
    assign next_start = 32'({r_row, 5'd0}) + 32'(WORD_BITS);

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_row       = r_row;
        n_prod      = r_prod;
        n_addr      = r_addr;
        n_status    = r_status;
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        mem_raddr   = (r_state == S_ALLOC_RD) ? r_row : free_row;
        mem_waddr   = (r_state == S_ALLOC_CHK) ? r_row : free_row;
        mem_wdata   = row_word;
        mem_we      = 1'b0;
        div_start   = 1'b0;

        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_addr = 32'd0;
                    if (i_req.operation == OP_ALLOC) begin
                        if (i_req.request_size != r_osize) begin
                            n_status = ST_SIZE;
                            n_state  = S_DONE;
                        end else if (r_used >= live_n) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_row   = '0;
                            n_state = S_ALLOC_RD;
                        end
                    end else begin
                        if (i_req.free_address == 32'd0) begin
                            n_status = ST_NULL;
                            n_state  = S_DONE;
                        end else if (i_req.free_address < r_base || r_osize == 16'd0) begin
                            n_status = ST_OUTSIDE;
                            n_state  = S_DONE;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                end
            end
            S_ALLOC_RD: begin
                n_state = S_ALLOC_CHK;
            end
            S_ALLOC_CHK: begin
                if (zero_found) begin
                    if (32'(alloc_idx) >= 32'(live_n)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = row_word | (WORD_BITS'(1) << zero_bit);
                        n_used    = r_used + 9'd1;
                        n_prod    = PRD_W'(alloc_idx) * PRD_W'(r_osize);
                        n_status  = ST_OK;
                        n_state   = S_ADDR;
                    end
                end else if (next_start >= 32'(live_n)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = S_ALLOC_RD;
                end
            end
            S_ADDR: begin
                // wraps modulo 2^32 like the address space
                n_addr  = r_base + 32'(r_prod);
                n_state = S_DONE;
            end
            S_DIV: begin
                if (div_done) begin
                    if (quotient >= 32'(live_n)) begin
                        n_status = ST_OUTSIDE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_FREE_RD;
                    end
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (row_word[free_bit]) begin
                    mem_we    = 1'b1;
                    mem_wdata = row_word & ~(WORD_BITS'(1) << free_bit);
                    if (r_used != 9'd0) begin
                        n_used = r_used - 9'd1;
                    end
                end
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp_valid        = 1'b1;
                    n_rsp.slot_address = r_addr;
                    n_rsp.status       = r_status;
                    n_rsp.used_slots   = r_used;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_prod   <= n_prod;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_rsp    <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // a row that was never written since reset or reconfiguration reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_take) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_row_vld[mem_waddr] <= 1'b1;
            end
            r_rd_vld <= r_row_vld[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= live_n)
        else $error("used count above pool size");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> r_state != S_IDLE)
        else $error("accepted request did not start");
    a_cfg_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && r_used != 9'd0) |=> $stable(r_base) && $stable(r_osize) && $stable(r_slots))
        else $error("register changed while slots in use");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside a free request");
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_ALLOC_CHK || r_state == S_FREE_CHK))
        else $error("bitmap written outside a check step");
`endif

endmodule
